### rtl/core/pod_hashed_key_value_store_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pod hashed key-value store
// Concurrent assertion wrappers that compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef POD_HASHED_KEY_VALUE_STORE_UNIT_ASSERT_SVH
`define POD_HASHED_KEY_VALUE_STORE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, quiet while reset is asserted.
`define PHKVS_ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Clocked check that also holds during reset.
`define PHKVS_ASSERT_RST(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed during or after reset");
`else
`define PHKVS_ASSERT_CLK(label, prop)
`define PHKVS_ASSERT_RST(label, prop)
`endif

`endif

### rtl/core/phkvs_pkg.sv
// ----------------------------------------------------------------------------
// phkvs_pkg
// Shared constants, types and helper functions of the pod hashed key-value store.
// ----------------------------------------------------------------------------
package phkvs_pkg;

    // Store geometry.
    localparam int PODS        = 4;
    localparam int POD_DEPTH   = 16;
    localparam int KEY_BYTES   = 8;
    localparam int VALUE_BYTES = 8;

    localparam int SLOTS  = PODS * POD_DEPTH;
    localparam int POD_W  = (PODS > 1) ? $clog2(PODS) : 1;
    localparam int SLOT_W = $clog2(POD_DEPTH);
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Width of the character segment that maps to one pod.
    localparam int POD_SEG     = 61 / PODS;
    localparam int POD_SEG_DIV = (POD_SEG > 0) ? POD_SEG : 1;

    // Field masks and the position of the first key character.
    localparam logic [63:0] KEY_MASK =
        (KEY_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);
    localparam logic [63:0] VALUE_MASK =
        (VALUE_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (8 * VALUE_BYTES)) - 64'd1);
    localparam int FIRST_LSB = 8 * (KEY_BYTES - 1);

    // Operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_BAD_KEY   = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    do_write;
        logic    scan_start;
        logic    scan_step;
        logic    take_hit;
        logic    load_out;
        status_t out_status;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic char_ok;
        logic op_read;
        logic hit;
        logic scan_last;
    } dp_stat_t;

    // True for a digit, an upper-case or a lower-case letter.
    function automatic logic char_valid(input logic [7:0] c);
        return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
               (c >= 8'd97 && c <= 8'd122);
    endfunction

    // Rank of a valid character: digits, then upper case, then lower case.
    function automatic logic [5:0] char_rank(input logic [7:0] c);
        logic [7:0] r;
        if (c >= 8'd48 && c <= 8'd57)
            r = c - 8'd48;
        else if (c >= 8'd65 && c <= 8'd90)
            r = c - 8'd65 + 8'd10;
        else
            r = c - 8'd97 + 8'd36;
        return r[5:0];
    endfunction

    // Pod of a valid character, clamped to the last pod. The quotient by the
    // segment width is found by comparing the rank against each segment start,
    // which also gives the clamp, since only the starts of pods 1 to PODS-1 are tested.
    function automatic logic [POD_W-1:0] pod_of_char(input logic [7:0] c);
        logic [5:0]       rank;
        logic [POD_W-1:0] q;
        rank = char_rank(c);
        q = '0;
        for (int k = 1; k < PODS; k++)
        begin
            if ({2'b00, rank} >= 8'(k * POD_SEG_DIV))
                q = POD_W'(k);
        end
        return q;
    endfunction

    // Next slot around a pod's ring.
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(POD_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    // Store address of a slot within a pod.
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [POD_W-1:0] pod,
                                                    input logic [SLOT_W-1:0] slot);
        return ADDR_W'(pod) * ADDR_W'(POD_DEPTH) + ADDR_W'(slot);
    endfunction

endpackage

### rtl/core/pod_hashed_key_value_store_unit.sv
// ----------------------------------------------------------------------------
// pod_hashed_key_value_store_unit
// Key-value store split into pods selected by the first key character.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready) transfers one request: op, key and
// value. A write stores key and value in the pod's ring at its write slot; a
// read scans the pod's ring once from its read slot and returns the value of
// the first matching key. The output channel (out_valid, out_ready) transfers
// exactly one result per request: status, value_out and pod_used.
// A read compares one stored entry per cycle over the 16 slots of a pod,
// read through the store RAM's read port. One request is in flight at a
// time: a new request is taken only after the last one's result is
// loaded. in_ready returns as that result is loaded, so a new request
// is taken while the result waits. When the receiver stalls, the finished
// result holds in the output register and the next request waits before
// its own result is loaded.
// Reset is asynchronous and active low: all ring pointers return to slot
// zero and every store entry reads as empty at once, with no clearing pass.
// ----------------------------------------------------------------------------
module pod_hashed_key_value_store_unit
    import phkvs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [63:0] key,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [63:0] value_out,
    output logic [1:0]  pod_used
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Sequencing.
    phkvs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Storage and compare.
    phkvs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .key       (key),
        .value     (value),
        .cmd       (cmd),
        .stat      (stat),
        .status    (status),
        .value_out (value_out),
        .pod_used  (pod_used)
    );

endmodule

### rtl/core/phkvs_ram.sv
// ----------------------------------------------------------------------------
// phkvs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module phkvs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; holds its data while no read is requested.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/phkvs_dp.sv
// ----------------------------------------------------------------------------
// phkvs_dp
// Datapath: input capture, pod decode, ring pointers, key and value stores,
// scan compare and the output register.
// ----------------------------------------------------------------------------
module phkvs_dp
    import phkvs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        op,
    input  logic [63:0] key,
    input  logic [63:0] value,
    input  ctrl_cmd_t   cmd,
    output dp_stat_t    stat,
    output logic [1:0]  status,
    output logic [63:0] value_out,
    output logic [1:0]  pod_used
);

    // Captured item.
    logic        op_reg;
    logic [63:0] key_reg;
    logic [63:0] value_reg;

    // Ring pointers per pod and valid bits per store entry.
    logic [SLOT_W-1:0] write_slot_reg [PODS];
    logic [SLOT_W-1:0] read_slot_reg [PODS];
    logic [SLOTS-1:0]  entry_valid_reg;

    // Scan state.
    logic [SLOT_W-1:0] data_slot_reg;
    logic [SLOT_W-1:0] cnt_reg;
    logic              data_valid_reg;

    // Output register.
    logic [1:0]  status_reg;
    logic [63:0] value_out_reg;
    logic [1:0]  pod_used_reg;

    logic [7:0]        lead_char;
    logic [POD_W-1:0]  pod;
    logic              char_ok;
    logic [SLOT_W-1:0] ws;
    logic [SLOT_W-1:0] issue_slot;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic              rd_en;
    logic [63:0]       key_rdata;
    logic [63:0]       val_rdata;

    // Pod decode from the first key character.
    assign lead_char = key_reg[FIRST_LSB +: 8];
    assign char_ok   = char_valid(lead_char);
    assign pod       = pod_of_char(lead_char);

    // Store addressing.
    assign ws         = write_slot_reg[pod];
    assign issue_slot = cmd.scan_start ? read_slot_reg[pod] : slot_inc(data_slot_reg);
    assign waddr      = slot_addr(pod, ws);
    assign raddr      = slot_addr(pod, issue_slot);
    assign rd_en      = cmd.scan_start | cmd.scan_step;

    phkvs_ram #(
        .WIDTH(64),
        .DEPTH(SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (cmd.do_write),
        .waddr (waddr),
        .wdata (key_reg),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (key_rdata)
    );

    phkvs_ram #(
        .WIDTH(64),
        .DEPTH(SLOTS)
    ) u_value_ram (
        .clk   (clk),
        .we    (cmd.do_write),
        .waddr (waddr),
        .wdata (value_reg),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (val_rdata)
    );

    // Status toward the controller.
    assign stat.char_ok   = char_ok;
    assign stat.op_read   = (op_reg == OP_READ);
    assign stat.hit       = data_valid_reg && (key_rdata == key_reg);
    assign stat.scan_last = (cnt_reg == SLOT_W'(POD_DEPTH - 1));

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            key_reg   <= key & KEY_MASK;
            value_reg <= value & VALUE_MASK;
        end
    end

    // Ring pointers and entry valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PODS; i++)
            begin
                write_slot_reg[i] <= '0;
                read_slot_reg[i]  <= '0;
            end
            entry_valid_reg <= '0;
        end
        else
        begin
            if (cmd.do_write)
            begin
                write_slot_reg[pod]    <= slot_inc(ws);
                entry_valid_reg[waddr] <= 1'b1;
            end
            if (cmd.take_hit)
            begin
                read_slot_reg[pod] <= slot_inc(data_slot_reg);
            end
        end
    end

    // Scan tracking: slot, count and valid bit of the entry now on the RAM outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_slot_reg  <= '0;
            cnt_reg        <= '0;
            data_valid_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            data_slot_reg  <= issue_slot;
            cnt_reg        <= cmd.scan_start ? '0 : cnt_reg + 1'b1;
            data_valid_reg <= entry_valid_reg[raddr];
        end
    end

    // Output register, loaded once per item.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status_reg    <= cmd.out_status;
            pod_used_reg  <= (cmd.out_status == STAT_BAD_KEY) ? 2'd0 : 2'(pod);
            value_out_reg <= (cmd.out_status == STAT_DONE && op_reg == OP_READ) ?
                             val_rdata : 64'd0;
        end
    end

    assign status    = status_reg;
    assign value_out = value_out_reg;
    assign pod_used  = pod_used_reg;

endmodule

### rtl/core/phkvs_ctrl.sv
// ----------------------------------------------------------------------------
// phkvs_ctrl
// Controller: sequences capture, write, ring scan and output transfer.
// ----------------------------------------------------------------------------
`include "pod_hashed_key_value_store_unit_assert.svh"

module phkvs_ctrl
    import phkvs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    state_t  state_reg;
    state_t  state_next;
    status_t code_reg;
    status_t code_next;
    logic    out_valid_reg;
    logic    out_valid_next;

    // State, status code and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            code_reg      <= STAT_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.out_status = code_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!stat.char_ok)
                begin
                    code_next  = STAT_BAD_KEY;
                    state_next = S_FINISH;
                end
                else if (!stat.op_read)
                begin
                    cmd.do_write = 1'b1;
                    code_next    = STAT_DONE;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    cmd.take_hit = 1'b1;
                    code_next    = STAT_DONE;
                    state_next   = S_FINISH;
                end
                else if (stat.scan_last)
                begin
                    code_next  = STAT_NOT_FOUND;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared by a transfer.
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    // A result never overwrites one that has not been transferred.
    `PHKVS_ASSERT_CLK(a_load_into_free, cmd.load_out |-> (!out_valid_reg || out_ready))
    // An accepted item is decoded in the next cycle.
    `PHKVS_ASSERT_CLK(a_accept_decode, (in_valid && in_ready) |=> (state_reg == S_DECODE))
    // A scan hit ends the scan with a done status.
    `PHKVS_ASSERT_CLK(a_hit_finish, (state_reg == S_SCAN && stat.hit) |=> (state_reg == S_FINISH && code_reg == STAT_DONE))
    // No result is offered while reset is held.
    `PHKVS_ASSERT_RST(a_reset_quiet, !rst_n |-> !out_valid_reg)

endmodule
